### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath types of the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int TEXT_CELLS_DEF = 4096;
  localparam int ROW_CELLS_DEF  = 80;
  localparam int VIEW_CELLS_DEF = 2000;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam int         TAB_SPAN = 4;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CELL_W    = 16;

  localparam logic [12:0] REGION_RST    = 13'd4096;
  localparam logic [7:0]  NORMAL_RST    = 8'd7;
  localparam logic [7:0]  HIGHLIGHT_RST = 8'd4;
  localparam logic [7:0]  HIDDEN_RST    = 8'd0;

  localparam logic [1:0] SS_NORMAL = 2'd0;
  localparam logic [1:0] SS_ENTRY  = 2'd1;
  localparam logic [1:0] SS_MATCH  = 2'd2;

  typedef enum logic [1:0] {
    CFG_REGION, CFG_NORMAL, CFG_HIGHLIGHT, CFG_HIDDEN
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_PUT, MODE_UP, MODE_DOWN, MODE_READ
  } mode_e;

  typedef enum logic [2:0] {
    RA_CUR_M1, RA_P_K, RA_PS_K, RA_P, RA_ITEM
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_CLEAR, WR_CHAR, WR_TAB, WR_NL, WR_BACK, WR_NORMAL_P, WR_HIGH_P, WR_SPACE_P
  } wr_sel_e;

  typedef enum logic [1:0] {CUR_HOLD, CUR_INC, CUR_DEC, CUR_PS} cur_op_e;
  typedef enum logic [1:0] {VS_HOLD, VS_DOWN, VS_UP} vs_op_e;
  typedef enum logic [1:0] {P_HOLD, P_ZERO, P_INC} p_op_e;
  typedef enum logic [1:0] {K_HOLD, K_ZERO, K_INC} k_op_e;

  typedef struct packed {
    logic    item_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    cur_op_e cur_op;
    vs_op_e  vs_op;
    p_op_e   p_op;
    k_op_e   k_op;
    logic    a_load;
    logic    ps_load;
    logic    entry_set;
    logic    entry_clr;
    logic    show_set;
    logic    show_clr;
    logic    clr_inc;
    logic    out_load;
  } tcw_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  is_esc;
    logic  is_tab;
    logic  is_nl;
    logic  is_bs;
    logic  entry;
    logic  show;
    logic  fit_tab;
    logic  fit_nl;
    logic  fit_char;
    logic  cur_zero;
    logic  rd_tab;
    logic  rd_nl;
    logic  rd_eq_a;
    logic  col_last;
    logic  k_last;
    logic  k_tab_last;
    logic  p_lt_ps;
    logic  p_next_eq_cur;
    logic  cur_gt_ps;
    logic  need_scroll;
    logic  can_scroll;
    logic  clr_last;
    logic  out_free;
  } tcw_sts_t;

endpackage

### rtl/tcw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels for console command words and result words.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  char_code;
  logic [11:0] cell_address;

  modport source (output valid, mode, char_code, cell_address, input ready);
  modport sink   (input valid, mode, char_code, cell_address, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cursor_pos;
  logic [11:0] screen_start;
  logic [7:0]  cell_char;
  logic [7:0]  cell_color;
  logic [1:0]  search_state;

  modport source (output valid, cursor_pos, screen_start, cell_char, cell_color,
                  search_state, input ready);
  modport sink   (input valid, cursor_pos, screen_start, cell_char, cell_color,
                  search_state, output ready);
endinterface

### rtl/text_console_writer_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_with_search
// Text-cell console engine with tabs, newlines, backspace, scrolling and
// in-place pattern search over a cell memory.
// Tabs, newlines, backspace over a newline run, erase and search work cell
// by cell; a plain character may then scroll the view row by row. Erase
// visits the cells below the pattern start, then the pattern cells; search
// compares cell pairs one at a time through the single read port of the
// cell memory. One word in flight at a time.
// Reset: a clearing pass writes all TEXT_CELLS cells before the first word
// is accepted; configuration writes are taken always.
// ----------------------------------------------------------------------------
module text_console_writer_with_search import tcw_pkg::*; #(
  parameter int TEXT_CELLS = TEXT_CELLS_DEF,
  parameter int ROW_CELLS  = ROW_CELLS_DEF,
  parameter int VIEW_CELLS = VIEW_CELLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tcw_in_if.sink               in_i,
  tcw_out_if.source            out_o
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .TEXT_CELLS(TEXT_CELLS),
    .ROW_CELLS (ROW_CELLS),
    .VIEW_CELLS(VIEW_CELLS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mode_i    (in_i.mode),
    .in_char_i    (in_i.char_code),
    .in_addr_i    (in_i.cell_address),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_cursor_o (out_o.cursor_pos),
    .out_screen_o (out_o.screen_start),
    .out_char_o   (out_o.cell_char),
    .out_color_o  (out_o.cell_color),
    .out_search_o (out_o.search_state)
  );

endmodule

### rtl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor/view/pattern registers, address and compare logic.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
  parameter int TEXT_CELLS = TEXT_CELLS_DEF,
  parameter int ROW_CELLS  = ROW_CELLS_DEF,
  parameter int VIEW_CELLS = VIEW_CELLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [1:0]           in_mode_i,
  input  logic [7:0]           in_char_i,
  input  logic [11:0]          in_addr_i,
  input  tcw_cmd_t             cmd_i,
  output tcw_sts_t             sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [11:0]          out_cursor_o,
  output logic [11:0]          out_screen_o,
  output logic [7:0]           out_char_o,
  output logic [7:0]           out_color_o,
  output logic [1:0]           out_search_o
);

  localparam int AW   = $clog2(TEXT_CELLS);
  localparam int LW   = $clog2(TEXT_CELLS + VIEW_CELLS + ROW_CELLS) + 1;
  localparam int COLW = $clog2(ROW_CELLS);

  logic [12:0]     region_q;
  logic [7:0]      normal_q, highlight_q, hidden_q;
  mode_e           mode_q;
  logic [7:0]      char_q;
  logic [11:0]     addr_q;
  logic [AW-1:0]   cursor_q, cursor_d;
  logic [COLW-1:0] col_q, col_d;
  logic [AW-1:0]   vs_q, vs_d;
  logic [AW-1:0]   ps_q;
  logic [COLW-1:0] ps_col_q;
  logic            entry_q, show_q;
  logic [AW-1:0]   p_q, p_d;
  logic [AW-1:0]   k_q, k_d;
  logic [7:0]      a_q;
  logic [AW-1:0]   clr_q;
  logic            out_valid_q;
  logic [11:0]     out_cursor_q, out_screen_q;
  logic [7:0]      out_char_q, out_color_q;
  logic [1:0]      out_search_q;

  logic [LW-1:0]     lim, cur_w, vs_w, view_end;
  logic [AW-1:0]     len;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CELL_W-1:0] wr_data, rdata;
  logic [7:0]        rd_char;
  logic              in_range;
  logic              col_last;

  assign lim      = (LW'(region_q) < LW'(TEXT_CELLS)) ? LW'(region_q) : LW'(TEXT_CELLS);
  assign cur_w    = LW'(cursor_q);
  assign vs_w     = LW'(vs_q);
  assign view_end = vs_w + LW'(VIEW_CELLS);
  assign len      = cursor_q - ps_q;
  assign rd_char  = rdata[7:0];
  assign in_range = LW'(addr_q) < LW'(TEXT_CELLS);
  assign col_last = (col_q == COLW'(ROW_CELLS - 1));

  always_comb begin
    sts_o.mode          = mode_q;
    sts_o.is_esc        = (char_q == CH_ESC);
    sts_o.is_tab        = (char_q == CH_TAB);
    sts_o.is_nl         = (char_q == CH_NL);
    sts_o.is_bs         = (char_q == CH_BS);
    sts_o.entry         = entry_q;
    sts_o.show          = show_q;
    sts_o.fit_tab       = (cur_w + LW'(TAB_SPAN)) < lim;
    sts_o.fit_nl        = (cur_w + LW'(ROW_CELLS)) < lim;
    sts_o.fit_char      = (cur_w + LW'(1)) < lim;
    sts_o.cur_zero      = (cursor_q == '0);
    sts_o.rd_tab        = (rd_char == CH_TAB);
    sts_o.rd_nl         = (rd_char == CH_NL);
    sts_o.rd_eq_a       = (rd_char == a_q);
    sts_o.col_last      = col_last;
    sts_o.k_last        = ((AW+1)'(k_q) + (AW+1)'(1)) == (AW+1)'(len);
    sts_o.k_tab_last    = (k_q == AW'(TAB_SPAN - 1));
    sts_o.p_lt_ps       = (p_q < ps_q);
    sts_o.p_next_eq_cur = ((AW+1)'(p_q) + (AW+1)'(1)) == (AW+1)'(cursor_q);
    sts_o.cur_gt_ps     = (cursor_q > ps_q);
    sts_o.need_scroll   = (cur_w >= view_end);
    sts_o.can_scroll    = (view_end < lim);
    sts_o.clr_last      = (clr_q == AW'(TEXT_CELLS - 1));
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RA_CUR_M1: rd_addr = cursor_q - AW'(1);
      RA_P_K:    rd_addr = p_q + k_q;
      RA_PS_K:   rd_addr = ps_q + k_q;
      RA_P:      rd_addr = p_q;
      RA_ITEM:   rd_addr = AW'(addr_q);
      default:   rd_addr = p_q;
    endcase
  end

  always_comb begin
    wr_addr = p_q;
    wr_data = {normal_q, CH_SPACE};
    unique case (cmd_i.wr_sel)
      WR_CLEAR: begin
        wr_addr = clr_q;
        wr_data = {NORMAL_RST, CH_SPACE};
      end
      WR_CHAR: begin
        wr_addr = cursor_q;
        wr_data = {(entry_q ? highlight_q : normal_q), char_q};
      end
      WR_TAB: begin
        wr_addr = cursor_q;
        wr_data = {hidden_q, CH_TAB};
      end
      WR_NL: begin
        wr_addr = cursor_q;
        wr_data = {hidden_q, CH_NL};
      end
      WR_BACK: begin
        wr_addr = cursor_q - AW'(1);
        wr_data = {normal_q, CH_SPACE};
      end
      WR_NORMAL_P: wr_data = {normal_q, rd_char};
      WR_HIGH_P:   wr_data = {highlight_q, rd_char};
      WR_SPACE_P:  wr_data = {normal_q, CH_SPACE};
      default:     wr_data = {normal_q, CH_SPACE};
    endcase
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(TEXT_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    case (cmd_i.cur_op)
      CUR_INC: begin
        cursor_d = cursor_q + AW'(1);
        col_d    = col_last ? '0 : col_q + COLW'(1);
      end
      CUR_DEC: begin
        cursor_d = cursor_q - AW'(1);
        col_d    = (col_q == '0) ? COLW'(ROW_CELLS - 1) : col_q - COLW'(1);
      end
      CUR_PS: begin
        cursor_d = ps_q;
        col_d    = ps_col_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    vs_d = vs_q;
    case (cmd_i.vs_op)
      VS_DOWN: if (view_end < lim) vs_d = vs_q + AW'(ROW_CELLS);
      VS_UP:   vs_d = (vs_q >= AW'(ROW_CELLS)) ? vs_q - AW'(ROW_CELLS) : '0;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd_i.p_op)
      P_ZERO:  p_d = '0;
      P_INC:   p_d = p_q + AW'(1);
      default: p_d = p_q;
    endcase
    case (cmd_i.k_op)
      K_ZERO:  k_d = '0;
      K_INC:   k_d = k_q + AW'(1);
      default: k_d = k_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q    <= REGION_RST;
      normal_q    <= NORMAL_RST;
      highlight_q <= HIGHLIGHT_RST;
      hidden_q    <= HIDDEN_RST;
      cursor_q    <= '0;
      col_q       <= '0;
      vs_q        <= '0;
      ps_q        <= '0;
      ps_col_q    <= '0;
      entry_q     <= 1'b0;
      show_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_REGION:    region_q    <= cfg_data_i;
          CFG_NORMAL:    normal_q    <= cfg_data_i[7:0];
          CFG_HIGHLIGHT: highlight_q <= cfg_data_i[7:0];
          CFG_HIDDEN:    hidden_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      cursor_q <= cursor_d;
      col_q    <= col_d;
      vs_q     <= vs_d;
      if (cmd_i.ps_load) begin
        ps_q     <= cursor_q;
        ps_col_q <= col_q;
      end
      if (cmd_i.entry_set) entry_q <= 1'b1;
      else if (cmd_i.entry_clr) entry_q <= 1'b0;
      if (cmd_i.show_set) show_q <= 1'b1;
      else if (cmd_i.show_clr) show_q <= 1'b0;
      if (cmd_i.clr_inc) clr_q <= clr_q + AW'(1);
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      mode_q <= mode_e'(in_mode_i);
      char_q <= in_char_i;
      addr_q <= in_addr_i;
    end
    p_q <= p_d;
    k_q <= k_d;
    if (cmd_i.a_load) a_q <= rd_char;
    if (cmd_i.out_load) begin
      out_cursor_q <= 12'(cursor_q);
      out_screen_q <= 12'(vs_q);
      out_char_q   <= (mode_q == MODE_READ && in_range) ? rd_char : 8'd0;
      out_color_q  <= (mode_q == MODE_READ && in_range) ? rdata[15:8] : 8'd0;
      out_search_q <= show_q ? SS_MATCH : (entry_q ? SS_ENTRY : SS_NORMAL);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_cursor_o = out_cursor_q;
  assign out_screen_o = out_screen_q;
  assign out_char_o   = out_char_q;
  assign out_color_o  = out_color_q;
  assign out_search_o = out_search_q;

endmodule

### rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for clearing, character handling, erase, search and scrolling.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tcw_sts_t sts_i,
  output tcw_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_TAB, S_NL, S_BS_CHK, S_BS_TAB, S_BS_NL_W,
    S_BS_NL_R, S_BS_NL_C, S_RE_RD, S_RE_WR, S_ER, S_HM_TOP, S_HM_A, S_HM_B,
    S_HM_C, S_HL_RD, S_HL_WR, S_SCROLL, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   skip_q, skip_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    skip_d  = skip_q;
    cmd_o   = '{rd_sel: RA_P, wr_sel: WR_SPACE_P, cur_op: CUR_HOLD, vs_op: VS_HOLD,
                p_op: P_HOLD, k_op: K_HOLD, default: 1'b0};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_CLEAR;
        cmd_o.clr_inc = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        skip_d = 1'b0;
        unique case (sts_i.mode)
          MODE_UP: begin
            cmd_o.vs_op = VS_UP;
            state_d     = S_DONE;
          end
          MODE_DOWN: begin
            cmd_o.vs_op = VS_DOWN;
            state_d     = S_DONE;
          end
          MODE_READ: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RA_ITEM;
            state_d      = S_DONE;
          end
          default: begin
            if (sts_i.show) begin
              if (sts_i.is_esc) begin
                cmd_o.entry_clr = 1'b1;
                cmd_o.show_clr  = 1'b1;
                cmd_o.p_op      = P_ZERO;
                skip_d          = 1'b1;
                state_d         = S_RE_RD;
              end else begin
                state_d = S_DONE;
              end
            end else if (sts_i.is_esc) begin
              if (!sts_i.entry) begin
                cmd_o.ps_load   = 1'b1;
                cmd_o.entry_set = 1'b1;
                state_d         = S_SCROLL;
              end else begin
                cmd_o.entry_clr = 1'b1;
                cmd_o.p_op      = P_ZERO;
                state_d         = S_RE_RD;
              end
            end else if (sts_i.is_tab) begin
              cmd_o.k_op = K_ZERO;
              state_d    = sts_i.fit_tab ? S_TAB : S_SCROLL;
            end else if (sts_i.is_nl) begin
              if (!sts_i.fit_nl) begin
                state_d = S_SCROLL;
              end else if (sts_i.entry) begin
                cmd_o.show_set = 1'b1;
                cmd_o.p_op     = P_ZERO;
                state_d        = S_HM_TOP;
              end else begin
                state_d = S_NL;
              end
            end else if (sts_i.is_bs) begin
              if (sts_i.cur_zero) begin
                state_d = S_SCROLL;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RA_CUR_M1;
                state_d      = S_BS_CHK;
              end
            end else begin
              if (sts_i.fit_char) begin
                cmd_o.wr_en  = 1'b1;
                cmd_o.wr_sel = WR_CHAR;
                cmd_o.cur_op = CUR_INC;
              end
              state_d = S_SCROLL;
            end
          end
        endcase
      end
      S_TAB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_TAB;
        cmd_o.cur_op = CUR_INC;
        cmd_o.k_op   = K_INC;
        if (sts_i.k_tab_last) state_d = S_SCROLL;
      end
      S_NL: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_NL;
        cmd_o.cur_op = CUR_INC;
        if (sts_i.col_last) state_d = S_SCROLL;
      end
      S_BS_CHK: begin
        if (sts_i.rd_tab) begin
          cmd_o.k_op = K_ZERO;
          state_d    = S_BS_TAB;
        end else if (sts_i.rd_nl) begin
          state_d = S_BS_NL_W;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_BACK;
          cmd_o.cur_op = CUR_DEC;
          state_d      = S_SCROLL;
        end
      end
      S_BS_TAB: begin
        if (sts_i.cur_zero) begin
          state_d = S_SCROLL;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_BACK;
          cmd_o.cur_op = CUR_DEC;
          cmd_o.k_op   = K_INC;
          if (sts_i.k_tab_last) state_d = S_SCROLL;
        end
      end
      S_BS_NL_W: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_BACK;
        cmd_o.cur_op = CUR_DEC;
        state_d      = S_BS_NL_R;
      end
      S_BS_NL_R: begin
        if (sts_i.cur_zero) begin
          state_d = S_SCROLL;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_CUR_M1;
          state_d      = S_BS_NL_C;
        end
      end
      S_BS_NL_C: begin
        state_d = sts_i.rd_nl ? S_BS_NL_W : S_SCROLL;
      end
      S_RE_RD: begin
        if (sts_i.p_lt_ps) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_P;
          state_d      = S_RE_WR;
        end else if (sts_i.cur_gt_ps) begin
          state_d = S_ER;
        end else begin
          state_d = skip_q ? S_DONE : S_SCROLL;
        end
      end
      S_RE_WR: begin
        cmd_o.wr_en  = !(sts_i.rd_tab || sts_i.rd_nl);
        cmd_o.wr_sel = WR_NORMAL_P;
        cmd_o.p_op   = P_INC;
        state_d      = S_RE_RD;
      end
      S_ER: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SPACE_P;
        cmd_o.p_op   = P_INC;
        if (sts_i.p_next_eq_cur) begin
          cmd_o.cur_op = CUR_PS;
          state_d      = skip_q ? S_DONE : S_SCROLL;
        end
      end
      S_HM_TOP: begin
        cmd_o.k_op = K_ZERO;
        state_d    = (sts_i.cur_gt_ps && sts_i.p_lt_ps) ? S_HM_A : S_SCROLL;
      end
      S_HM_A: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_P_K;
        state_d      = S_HM_B;
      end
      S_HM_B: begin
        cmd_o.a_load = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_PS_K;
        state_d      = S_HM_C;
      end
      S_HM_C: begin
        if (!sts_i.rd_eq_a) begin
          cmd_o.p_op = P_INC;
          state_d    = S_HM_TOP;
        end else if (sts_i.k_last) begin
          cmd_o.k_op = K_ZERO;
          state_d    = S_HL_RD;
        end else begin
          cmd_o.k_op = K_INC;
          state_d    = S_HM_A;
        end
      end
      S_HL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_P;
        state_d      = S_HL_WR;
      end
      S_HL_WR: begin
        cmd_o.wr_en  = !sts_i.rd_tab;
        cmd_o.wr_sel = WR_HIGH_P;
        cmd_o.p_op   = P_INC;
        cmd_o.k_op   = K_INC;
        state_d      = sts_i.k_last ? S_HM_TOP : S_HL_RD;
      end
      S_SCROLL: begin
        if (sts_i.need_scroll && sts_i.can_scroll) begin
          cmd_o.vs_op = VS_DOWN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      skip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      skip_q  <= skip_d;
    end
  end

endmodule

### rtl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the console handshakes and result words.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_cursor,
  input logic [1:0]  out_search
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_cursor) && $stable(out_search))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous one in progress");

  a_search_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_search != 2'd3)
    else $error("invalid search state code");

endmodule

bind text_console_writer_with_search tcw_checker u_tcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_cursor (out_o.cursor_pos),
  .out_search (out_o.search_state)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives console command words into text_console_writer_with_search and
// checks every result word against an in-bench model of the console: cell
// memory, cursor, view start and search state. Directed words cover the
// special cases, then random typing with pattern searches runs under
// several register settings and flow-control mixes.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int NCELLS   = TEXT_CELLS_DEF;
  localparam int ROW      = ROW_CELLS_DEF;
  localparam int VIEW     = VIEW_CELLS_DEF;
  localparam int WDOG_MAX = 400000;

  typedef struct {
    logic [11:0] cursor;
    logic [11:0] start;
    logic [7:0]  ch;
    logic [7:0]  col;
    logic [1:0]  ss;
  } console_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  tcw_in_if  in_if();
  tcw_out_if out_if();

  text_console_writer_with_search u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_if), .out_o(out_if)
  );

  // console model state
  logic [15:0] cells[NCELLS];
  int unsigned cur, vstart, pstart;
  bit entry, show;
  int unsigned region, c_norm, c_high, c_hid;

  console_word_t console_results_q[$];
  int fail_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned lim_cells();
    return (region < NCELLS) ? region : NCELLS;
  endfunction

  function automatic int unsigned ch_at(int unsigned a);
    return (a < NCELLS) ? cells[a][7:0] : 0;
  endfunction

  function automatic void put_cell(int unsigned a, int unsigned ch, int unsigned col);
    if (a < NCELLS) cells[a] = {col[7:0], ch[7:0]};
  endfunction

  function automatic void view_down();
    if (vstart + VIEW < lim_cells()) vstart += ROW;
  endfunction

  function automatic void mark_matches();
    int unsigned len, p, k;
    bit same;
    if (cur <= pstart) return;
    len = cur - pstart;
    p = 0;
    while (p < pstart) begin
      same = 1;
      for (k = 0; k < len; k++) begin
        if (ch_at(p + k) != ch_at(pstart + k)) begin
          same = 0;
          break;
        end
      end
      if (same) begin
        for (k = 0; k < len; k++) begin
          if (ch_at(p) != CH_TAB) put_cell(p, ch_at(p), c_high);
          p++;
        end
      end else begin
        p++;
      end
    end
  endfunction

  function automatic void erase_pattern();
    int unsigned p, c;
    for (p = 0; p < pstart; p++) begin
      c = ch_at(p);
      if (c != CH_TAB && c != CH_NL) put_cell(p, c, c_norm);
    end
    if (cur > pstart) begin
      for (p = pstart; p < cur; p++) put_cell(p, CH_SPACE, c_norm);
      cur = pstart;
    end
  endfunction

  function automatic void back_one();
    cur--;
    put_cell(cur, CH_SPACE, c_norm);
  endfunction

  function automatic void type_char(logic [7:0] ch);
    int unsigned lim, i, nxt, prev, prev_vs;
    lim = lim_cells();
    if (show) begin
      if (ch == CH_ESC) begin
        erase_pattern();
        entry = 0;
        show = 0;
      end
      return;
    end
    if (ch == CH_ESC) begin
      if (!entry) begin
        pstart = cur;
        entry = 1;
      end else begin
        entry = 0;
        erase_pattern();
      end
    end else if (ch == CH_TAB) begin
      if (cur + TAB_SPAN < lim) begin
        for (i = 0; i < TAB_SPAN; i++) begin
          put_cell(cur, CH_TAB, c_hid);
          cur++;
        end
      end
    end else if (ch == CH_NL) begin
      if (cur + ROW < lim) begin
        if (entry) begin
          show = 1;
          mark_matches();
        end else begin
          nxt = ROW * (cur / ROW + 1);
          while (cur < nxt) begin
            put_cell(cur, CH_NL, c_hid);
            cur++;
          end
        end
      end
    end else if (ch == CH_BS) begin
      if (cur > 0) begin
        prev = ch_at(cur - 1);
        if (prev == CH_TAB) begin
          for (i = 0; i < TAB_SPAN && cur > 0; i++) back_one();
        end else if (prev == CH_NL) begin
          while (cur > 0 && ch_at(cur - 1) == CH_NL) back_one();
        end else begin
          back_one();
        end
      end
    end else begin
      if (cur + 1 < lim) begin
        put_cell(cur, ch, entry ? c_high : c_norm);
        cur++;
      end
    end
    while (cur >= vstart + VIEW) begin
      prev_vs = vstart;
      view_down();
      if (vstart == prev_vs) break;
    end
  endfunction

  function automatic console_word_t predict_console(mode_e m, logic [7:0] ch,
                                                    logic [11:0] addr);
    console_word_t r;
    r.ch = '0;
    r.col = '0;
    case (m)
      MODE_PUT: type_char(ch);
      MODE_UP: begin
        if (vstart > 0) vstart = (vstart >= ROW) ? vstart - ROW : 0;
      end
      MODE_DOWN: view_down();
      default: begin
        r.ch = cells[addr][7:0];
        r.col = cells[addr][15:8];
      end
    endcase
    r.cursor = cur[11:0];
    r.start = vstart[11:0];
    r.ss = show ? SS_MATCH : (entry ? SS_ENTRY : SS_NORMAL);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    fail_cnt++;
  endtask

  // result checker and receiver flow control
  initial begin
    console_word_t w;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (console_results_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          w = console_results_q.pop_front();
          if (out_if.cursor_pos !== w.cursor)
            report_mismatch("cursor_pos", int'(out_if.cursor_pos), int'(w.cursor));
          if (out_if.screen_start !== w.start)
            report_mismatch("screen_start", int'(out_if.screen_start), int'(w.start));
          if (out_if.cell_char !== w.ch)
            report_mismatch("cell_char", int'(out_if.cell_char), int'(w.ch));
          if (out_if.cell_color !== w.col)
            report_mismatch("cell_color", int'(out_if.cell_color), int'(w.col));
          if (out_if.search_state !== w.ss)
            report_mismatch("search_state", int'(out_if.search_state), int'(w.ss));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_word(mode_e m, logic [7:0] ch, logic [11:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.char_code <= ch;
    in_if.cell_address <= addr;
    do @(posedge clk_i); while (!in_if.ready);
    console_results_q.push_back(predict_console(m, ch, addr));
  endtask

  task automatic key(logic [7:0] ch);
    send_word(MODE_PUT, ch, '0);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (console_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    case (idx)
      CFG_REGION:    region = val & 13'h1fff;
      CFG_NORMAL:    c_norm = val & 8'hff;
      CFG_HIGHLIGHT: c_high = val & 8'hff;
      default:       c_hid = val & 8'hff;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_word();
    int r;
    r = $urandom_range(99);
    if (show) begin
      if (r < 70) key(CH_ESC);
      else if (r < 85) key(8'($urandom_range(255)));
      else send_word(mode_e'($urandom_range(3)), 8'($urandom_range(255)),
                     12'($urandom_range(4095)));
    end else if (entry) begin
      if (r < 55 && cur < pstart + 4) key(8'(97 + $urandom_range(2)));
      else if (r < 72) key(CH_NL);
      else if (r < 88) key(CH_ESC);
      else key(CH_BS);
    end else begin
      if (r < 40) key(8'(97 + $urandom_range(2)));
      else if (r < 47) key(8'($urandom_range(255)));
      else if (r < 55) key(CH_TAB);
      else if (r < 63) key(CH_NL);
      else if (r < 76) key(CH_BS);
      else if (r < 81) key(CH_ESC);
      else if (r < 86) send_word(MODE_UP, 8'($urandom_range(255)), 12'($urandom_range(4095)));
      else if (r < 91) send_word(MODE_DOWN, 8'($urandom_range(255)),
                                 12'($urandom_range(4095)));
      else send_word(MODE_READ, 8'($urandom_range(255)), 12'($urandom_range(4095)));
    end
  endtask

  task automatic test_directed();
    key(8'd0);
    key(8'hff);
    key(CH_TAB);
    key(CH_BS);
    key(CH_NL);
    key(CH_BS);
    key(CH_BS);
    key(CH_BS);
    key(8'd97);
    key(8'd98);
    key(CH_ESC);
    key(8'd97);
    key(8'd98);
    key(CH_NL);
    key(8'd120);
    send_word(MODE_READ, '0, 12'd0);
    key(CH_ESC);
    key(CH_ESC);
    key(CH_BS);
    key(CH_BS);
    key(CH_NL);
    send_word(MODE_READ, '0, 12'hfff);
    send_word(MODE_UP, '0, '0);
    send_word(MODE_DOWN, '0, '0);
    send_word(MODE_UP, '0, '0);
  endtask

  task automatic test_random(int n);
    repeat (n) random_word();
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 400;
    repeat (20) random_word();
    drain();
    repeat (10) random_word();
  endtask

  task automatic test_fill_region();
    write_reg(CFG_REGION, 2000);
    repeat (30) key(CH_NL);
    repeat (10) key(8'd97);
    key(CH_TAB);
    repeat (4) send_word(MODE_DOWN, '0, '0);
    repeat (30) send_word(MODE_UP, '0, '0);
    test_random(100);
  endtask

  initial begin
    region = REGION_RST;
    c_norm = NORMAL_RST;
    c_high = HIGHLIGHT_RST;
    c_hid = HIDDEN_RST;
    for (int i = 0; i < NCELLS; i++) cells[i] = {NORMAL_RST, CH_SPACE};
    cur = 0;
    vstart = 0;
    pstart = 0;
    entry = 0;
    show = 0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_PUT;
    in_if.char_code = '0;
    in_if.cell_address = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(150);
    test_backpressure();
    send_idle_pct = 67;
    write_reg(CFG_NORMAL, 255);
    write_reg(CFG_HIGHLIGHT, 0);
    write_reg(CFG_HIDDEN, 255);
    test_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    write_reg(CFG_NORMAL, 0);
    write_reg(CFG_HIGHLIGHT, 255);
    write_reg(CFG_HIDDEN, $urandom_range(255));
    test_random(200);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    test_fill_region();
    write_reg(CFG_REGION, 8191);
    write_reg(CFG_NORMAL, $urandom_range(255));
    write_reg(CFG_HIGHLIGHT, $urandom_range(255));
    test_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_REGION, 4096);
    test_random(150);

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
